// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and types of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // broadcast to every cell in the accept cycle
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/spq_req_if.sv -----
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: insert or remove, with priority and tag.
// ----------------------------------------------------------------------------
interface spq_req_if #(
   parameter int PRIO_BITS = 8,
   parameter int TAG_BITS  = 16
) ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [PRIO_BITS-1:0] priority_req;
   logic [TAG_BITS-1:0]  tag;

   modport source (output valid, kind, priority_req, tag, input ready);
   modport sink   (input valid, kind, priority_req, tag, output ready);
endinterface

// ----- hw/rtl/spq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: status, removed entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if #(
   parameter int PRIO_BITS = 8,
   parameter int TAG_BITS  = 16,
   parameter int CNT_BITS  = 5
) ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [TAG_BITS-1:0]  out_tag;
   logic [PRIO_BITS-1:0] out_priority;
   logic [CNT_BITS-1:0]  occupancy;

   modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
   modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array. Holds, takes the new entry, takes the left
// neighbor (insert shift) or takes the right neighbor (remove shift).
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int PRIO_BITS = 8,
   parameter int TAG_BITS  = 16
) (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic [PRIO_BITS-1:0]   new_prio,
   input  logic [TAG_BITS-1:0]    new_tag,
   input  logic                   left_keep,
   input  logic [PRIO_BITS-1:0]   left_prio,
   input  logic [TAG_BITS-1:0]    left_tag,
   input  logic [PRIO_BITS-1:0]   right_prio,
   input  logic [TAG_BITS-1:0]    right_tag,
   output logic                   keep,
   output logic [PRIO_BITS-1:0]   prio,
   output logic [TAG_BITS-1:0]    tag
);

   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   // equal priority stays ahead of the new entry
   assign keep = occupied && (prio_ff <= new_prio);

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (ctrl.ins) begin
         if (!keep) begin
            if (left_keep) begin
               prio_in = new_prio;
               tag_in  = new_tag;
            end else begin
               prio_in = left_prio;
               tag_in  = left_tag;
            end
         end
      end else if (ctrl.rem) begin
         prio_in = right_prio;
         tag_in  = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign prio = prio_ff;
   assign tag  = tag_ff;

endmodule

// ----- hw/rtl/stable_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded stable priority queue built as a row of sorted cells.
//
//   channel  | dir | payload                                      | handshake
//   req_ch   | in  | kind, priority_req, tag                      | valid/ready
//   rsp_ch   | out | status, out_tag, out_priority, occupancy     | valid/ready
//
// One item per cycle: all cells shift or hold in the accept cycle, and the
// result is in the output register on the next cycle.
// A held result stalls requests only if rsp_ch.ready is low.
// Reset clears the entry count and the output valid; cell contents are not
// cleared and entries at or above the count are never read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_BITS   = 8,
   parameter int TAG_BITS    = 16
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic                  accept;
   logic                  full;
   logic                  empty;
   spq_pkg::cell_ctrl_type ctrl;

   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                  cell_keep [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0]  cell_prio [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]   cell_tag  [QUEUE_DEPTH];

   logic                  rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [PRIO_BITS-1:0]  rsp_prio_ff, rsp_prio_in;
   logic [CNT_BITS-1:0]   rsp_occ_ff, rsp_occ_in;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty        = (count_ff == '0);

   assign ctrl.ins = accept && (req_ch.kind == spq_pkg::KIND_INSERT) && !full;
   assign ctrl.rem = accept && (req_ch.kind == spq_pkg::KIND_REMOVE) && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 left_keep;
      logic [PRIO_BITS-1:0] left_prio;
      logic [TAG_BITS-1:0]  left_tag;
      logic [PRIO_BITS-1:0] right_prio;
      logic [TAG_BITS-1:0]  right_tag;

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_prio = '0;
         assign left_tag  = '0;
      end else begin : g_mid
         assign left_keep = cell_keep[i-1];
         assign left_prio = cell_prio[i-1];
         assign left_tag  = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_prio = '0;
         assign right_tag  = '0;
      end else begin : g_body
         assign right_prio = cell_prio[i+1];
         assign right_tag  = cell_tag[i+1];
      end

      spq_cell #(
         .PRIO_BITS (PRIO_BITS),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (count_ff > CNT_BITS'(i)),
         .new_prio   (req_ch.priority_req),
         .new_tag    (req_ch.tag),
         .left_keep  (left_keep),
         .left_prio  (left_prio),
         .left_tag   (left_tag),
         .right_prio (right_prio),
         .right_tag  (right_tag),
         .keep       (cell_keep[i]),
         .prio       (cell_prio[i]),
         .tag        (cell_tag[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = '0;
         rsp_prio_in  = '0;
         rsp_occ_in   = count_in;
         if (req_ch.kind == spq_pkg::KIND_INSERT) begin
            rsp_status_in = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
         end else if (empty) begin
            rsp_status_in = spq_pkg::ST_EMPTY;
         end else begin
            rsp_status_in = spq_pkg::ST_REMOVED;
            rsp_tag_in    = cell_tag[0];
            rsp_prio_in   = cell_prio[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.out_tag      = rsp_tag_ff;
   assign rsp_ch.out_priority = rsp_prio_ff;
   assign rsp_ch.occupancy    = rsp_occ_ff;

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(QUEUE_DEPTH))
   `ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.ins, count_ff == $past(count_ff) + CNT_BITS'(1))
   `ASSERT_SAME(a_head_sorted, clock, reset, count_ff >= CNT_BITS'(2), cell_prio[0] <= cell_prio[1])
   `ASSERT_NEXT(a_result_held, clock, reset, accept, rsp_valid_ff)

endmodule

// ----- tb/spq_queue_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_queue_checker
// Watches the request and response channels of the stable priority queue,
// keeps its own sorted copy of the stored entries, and compares every
// response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module spq_queue_checker #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_BITS   = 8,
   parameter int TAG_BITS    = 16,
   parameter int CNT_BITS    = 5
) (
   input  logic clock,
   input  logic reset,
   spq_req_if   req_ch,
   spq_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   responses_owed
);

   typedef struct packed {
      spq_pkg::status_type  status;
      logic [TAG_BITS-1:0]  tag;
      logic [PRIO_BITS-1:0] prio;
      logic [CNT_BITS-1:0]  occupancy;
   } queue_response_type;

   logic [PRIO_BITS-1:0] held_prio [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  held_tag  [QUEUE_DEPTH];
   int                   held_count;
   queue_response_type   owed_responses [$];

   // updates the held entries and returns the response the block should give
   function automatic queue_response_type apply_request(
      input logic                 kind,
      input logic [PRIO_BITS-1:0] prio,
      input logic [TAG_BITS-1:0]  tag
   );
      queue_response_type rsp;
      int                 slot;
      int                 i;
      rsp = '0;
      if (kind == spq_pkg::KIND_INSERT) begin
         if (held_count >= QUEUE_DEPTH) begin
            rsp.status = spq_pkg::ST_FULL;
         end else begin
            // new entry goes behind everything of equal or smaller priority
            slot = 0;
            while (slot < held_count && held_prio[slot] <= prio)
               slot++;
            for (i = held_count; i > slot; i--) begin
               held_prio[i] = held_prio[i-1];
               held_tag[i]  = held_tag[i-1];
            end
            held_prio[slot] = prio;
            held_tag[slot]  = tag;
            held_count++;
            rsp.status = spq_pkg::ST_INSERTED;
         end
      end else begin
         if (held_count == 0) begin
            rsp.status = spq_pkg::ST_EMPTY;
         end else begin
            rsp.status = spq_pkg::ST_REMOVED;
            rsp.tag    = held_tag[0];
            rsp.prio   = held_prio[0];
            for (i = 1; i < held_count; i++) begin
               held_prio[i-1] = held_prio[i];
               held_tag[i-1]  = held_tag[i];
            end
            held_count--;
         end
      end
      rsp.occupancy = CNT_BITS'(held_count);
      return rsp;
   endfunction

   always @(posedge clock) begin
      queue_response_type want;
      if (reset) begin
         held_count = 0;
         owed_responses.delete();
         mismatch_count = 0;
      end else begin
         // response first: the response is registered, so it never belongs to
         // the request accepted on the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with nothing outstanding: %s %0d tag %h prio %h occ %0d",
                           $realtime, "status", rsp_ch.status, rsp_ch.out_tag,
                           rsp_ch.out_priority, rsp_ch.occupancy);
            end else begin
               want = owed_responses.pop_front();
               if (want.status !== rsp_ch.status || want.tag !== rsp_ch.out_tag ||
                   want.prio !== rsp_ch.out_priority ||
                   want.occupancy !== rsp_ch.occupancy) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected status %0d tag %h prio %h occ %0d, %s",
                              $realtime, want.status, want.tag, want.prio,
                              want.occupancy, "got");
                  if (mismatch_count <= 10)
                     $display("   got status %0d tag %h prio %h occ %0d",
                              rsp_ch.status, rsp_ch.out_tag, rsp_ch.out_priority,
                              rsp_ch.occupancy);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            owed_responses.push_back(apply_request(req_ch.kind, req_ch.priority_req,
                                                   req_ch.tag));
      end
      responses_owed = owed_responses.size();
   end

endmodule

// ----- tb/stable_priority_queue_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top_test
// Drives inserts and removes into the stable priority queue with random
// pacing on both channels, one long response hold-off, and a checker that
// predicts every response.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_test;

   localparam int QUEUE_DEPTH    = 16;
   localparam int PRIO_BITS      = 8;
   localparam int TAG_BITS       = 16;
   localparam int RANDOM_ITEMS   = 750;
   localparam int TAIL_ITEMS     = 120;
   localparam int HOLD_START     = 300;
   localparam int HOLD_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 1000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   responses_owed;
   int   stall_cycles;
   bit   req_gaps_on;
   bit   rsp_gaps_on;
   bit   hold_rsp_request;
   bit   hold_rsp_done;

   spq_req_if #(.PRIO_BITS(PRIO_BITS), .TAG_BITS(TAG_BITS)) req_ch ();
   spq_rsp_if #(.PRIO_BITS(PRIO_BITS), .TAG_BITS(TAG_BITS)) rsp_ch ();

   stable_priority_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .PRIO_BITS  (PRIO_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   spq_queue_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .PRIO_BITS  (PRIO_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .mismatch_count(mismatch_count),
      .responses_owed(responses_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_request(input logic kind, input logic [PRIO_BITS-1:0] prio,
                                input logic [TAG_BITS-1:0] tag);
      if (req_gaps_on && !(hold_rsp_request && !hold_rsp_done) &&
          $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.priority_req <= prio;
      req_ch.tag          <= tag;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int                   i;
      int                   sent;
      int                   seg_len;
      int                   seg_pos;
      int                   insert_pct;
      int                   prio_mode;
      logic [PRIO_BITS-1:0] prio_base;
      logic [PRIO_BITS-1:0] prio;
      bit                   seg_req_gaps;
      bit                   seg_rsp_gaps;

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.kind         = spq_pkg::KIND_INSERT;
      req_ch.priority_req = '0;
      req_ch.tag          = '0;
      req_gaps_on         = 1'b1;
      rsp_gaps_on         = 1'b1;
      hold_rsp_request    = 1'b0;
      hold_rsp_done       = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty remove, extremes, ties, fill to full, rejected insert
      offer_request(spq_pkg::KIND_REMOVE, 8'hA5, 16'h5A5A);
      offer_request(spq_pkg::KIND_INSERT, 8'hFF, 16'hFFFF);
      offer_request(spq_pkg::KIND_INSERT, 8'h00, 16'h0000);
      offer_request(spq_pkg::KIND_INSERT, 8'h80, 16'h8001);
      offer_request(spq_pkg::KIND_INSERT, 8'h80, 16'h8002);
      offer_request(spq_pkg::KIND_INSERT, 8'h80, 16'h8003);
      offer_request(spq_pkg::KIND_REMOVE, 8'hFF, 16'hFFFF);
      offer_request(spq_pkg::KIND_REMOVE, 8'h00, 16'h0000);
      for (i = 0; i < QUEUE_DEPTH - 3; i++)
         offer_request(spq_pkg::KIND_INSERT, PRIO_BITS'((i % 4) * 85),
                       TAG_BITS'(16'h1000 + i));
      offer_request(spq_pkg::KIND_INSERT, 8'h00, 16'hFFFF);
      for (i = 0; i < 3; i++)
         offer_request(spq_pkg::KIND_REMOVE, PRIO_BITS'($urandom), TAG_BITS'($urandom));

      // random: segments with their own insert mix, priority spread and pacing
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: insert_pct = 20;
            1: insert_pct = 50;
            default: insert_pct = 80;
         endcase
         prio_mode    = $urandom_range(0, 3);
         prio_base    = PRIO_BITS'($urandom);
         seg_req_gaps = $urandom_range(0, 3) != 0;
         seg_rsp_gaps = $urandom_range(0, 3) != 0;
         for (seg_pos = 0; seg_pos < seg_len && sent < RANDOM_ITEMS; seg_pos++) begin
            req_gaps_on = seg_req_gaps && sent < RANDOM_ITEMS - TAIL_ITEMS;
            rsp_gaps_on = seg_rsp_gaps && sent < RANDOM_ITEMS - TAIL_ITEMS;
            if (sent == HOLD_START)
               hold_rsp_request = 1'b1;
            case (prio_mode)
               0: prio = PRIO_BITS'($urandom);
               1: prio = PRIO_BITS'($urandom_range(0, 3));    // heavy ties
               2: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default: prio = prio_base + PRIO_BITS'($urandom_range(0, 7));
            endcase
            offer_request(($urandom_range(0, 99) < insert_pct) ? spq_pkg::KIND_INSERT
                                                                : spq_pkg::KIND_REMOVE,
                          prio, TAG_BITS'($urandom));
            sent++;
         end
      end

      req_ch.valid <= 1'b0;
      wait (responses_owed == 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && responses_owed == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : response_pacing
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request && !hold_rsp_done) begin
            // long hold-off so requests back up behind the held response
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp_done = 1'b1;
         end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
